// ===== design/u8d_pkg.sv =====
// Package: shared widths, byte classes, length codes and item types of the UTF-8 decoder.
`timescale 1ns / 1ps
`default_nettype none
package u8d_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CP_W   = 16;
  localparam int unsigned LEN_W  = 2;

  localparam logic [BYTE_W-1:0] ASCII_LO  = 8'h20;
  localparam logic [BYTE_W-1:0] ASCII_HI  = 8'h7E;
  localparam logic [BYTE_W-1:0] ASCII_TOP = 8'h80;
  localparam logic [BYTE_W-1:0] LEAD2_LO  = 8'hC2;
  localparam logic [BYTE_W-1:0] LEAD2_HI  = 8'hDF;
  localparam logic [BYTE_W-1:0] LEAD3_LO  = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD3_HI  = 8'hEF;
  localparam logic [1:0]        CONT_TAG  = 2'b10;

  localparam logic [CP_W-1:0] MIN_CP3   = 16'h0800;
  localparam logic [CP_W-1:0] SURR_LO   = 16'hD800;
  localparam logic [CP_W-1:0] SURR_HI   = 16'hDFFF;

  localparam logic [LEN_W-1:0] SEQ_LEN_NONE = 2'd0;
  localparam logic [LEN_W-1:0] SEQ_LEN_1    = 2'd1;
  localparam logic [LEN_W-1:0] SEQ_LEN_2    = 2'd2;
  localparam logic [LEN_W-1:0] SEQ_LEN_3    = 2'd3;

  localparam logic [1:0] PEND_LEAD = 2'd0;
  localparam logic [1:0] PEND_ONE  = 2'd1;
  localparam logic [1:0] PEND_TWO  = 2'd2;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              last_byte;
  } u8d_byte_t;

  typedef struct packed {
    logic [CP_W-1:0]  code_point;
    logic [LEN_W-1:0] seq_length;
    logic             bad_sequence;
    logic             record_done;
  } u8d_res_t;

  typedef struct packed {
    logic vld;
    logic fire;
  } u8d_step_t;

endpackage
`default_nettype wire

// ===== design/u8d_if.sv =====
// Interfaces: byte input channel and decoded result channel.
`timescale 1ns / 1ps
`default_nettype none
interface u8d_byte_if import u8d_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface u8d_cp_if import u8d_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CP_W-1:0]  code_point;
  logic [LEN_W-1:0] seq_length;
  logic             bad_sequence;
  logic             record_done;

  modport source (output valid, output code_point, output seq_length,
                  output bad_sequence, output record_done, input ready);
  modport sink   (input valid, input code_point, input seq_length,
                  input bad_sequence, input record_done, output ready);
endinterface
`default_nettype wire

// ===== design/u8d_in_stage.sv =====
// Input register: captures one byte item and hands it to the decoder.
`timescale 1ns / 1ps
`default_nettype none
module u8d_in_stage import u8d_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire u8d_byte_t in_item,
  input  wire logic      slot_free,
  output u8d_step_t      step,
  output u8d_byte_t      s1_item
);

  logic      s1_vld_r;
  logic      s1_vld_nxt;
  u8d_byte_t s1_item_r;
  logic      fire;

  assign fire     = s1_vld_r && slot_free;
  assign in_ready = !s1_vld_r || fire;

  always_comb begin
    s1_vld_nxt = s1_vld_r;
    if (fire) begin
      s1_vld_nxt = 1'b0;
    end
    if (in_valid && in_ready) begin
      s1_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r <= in_item;
    end
  end

  assign step.vld  = s1_vld_r;
  assign step.fire = fire;
  assign s1_item   = s1_item_r;

endmodule
`default_nettype wire

// ===== design/u8d_core.sv =====
// Decoder core: sequence state and per-byte decode into zero or one result.
`timescale 1ns / 1ps
`default_nettype none
module u8d_core import u8d_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire u8d_step_t step,
  input  wire u8d_byte_t s1_item,
  output logic           res_vld,
  output u8d_res_t       res
);

  logic [1:0]       pending_r, pending_nxt;
  logic [CP_W-1:0]  partial_r, partial_nxt;
  logic [LEN_W-1:0] size_r, size_nxt;
  logic             discard_r, discard_nxt;

  logic [BYTE_W-1:0] b;
  logic              last;
  logic [CP_W-1:0]   value;
  logic              good;
  logic              bad;
  logic [CP_W-1:0]   good_cp;
  logic [LEN_W-1:0]  good_len;

  assign b     = s1_item.data_byte;
  assign last  = s1_item.last_byte;
  assign value = partial_r | {10'b0, b[5:0]};

  always_comb begin
    pending_nxt = pending_r;
    partial_nxt = partial_r;
    size_nxt    = size_r;
    discard_nxt = discard_r;
    good        = 1'b0;
    bad         = 1'b0;
    good_cp     = '0;
    good_len    = SEQ_LEN_NONE;
    if (discard_r) begin
      if (last) begin
        discard_nxt = 1'b0;
        pending_nxt = PEND_LEAD;
        partial_nxt = '0;
        size_nxt    = SEQ_LEN_NONE;
      end
    end else if (pending_r == PEND_LEAD) begin
      if (b < ASCII_TOP) begin
        if (b < ASCII_LO || b > ASCII_HI) begin
          bad = 1'b1;
        end else begin
          good     = 1'b1;
          good_cp  = {8'b0, b};
          good_len = SEQ_LEN_1;
        end
      end else if (b inside {[LEAD2_LO:LEAD2_HI]}) begin
        if (last) begin
          bad = 1'b1;
        end else begin
          partial_nxt = {5'b0, b[4:0], 6'b0};
          pending_nxt = PEND_ONE;
          size_nxt    = SEQ_LEN_2;
        end
      end else if (b inside {[LEAD3_LO:LEAD3_HI]}) begin
        if (last) begin
          bad = 1'b1;
        end else begin
          partial_nxt = {b[3:0], 12'b0};
          pending_nxt = PEND_TWO;
          size_nxt    = SEQ_LEN_3;
        end
      end else begin
        bad = 1'b1;
      end
    end else if (b[7:6] != CONT_TAG) begin
      bad = 1'b1;
    end else if (pending_r == PEND_ONE) begin
      if (size_r == SEQ_LEN_3 &&
          (value < MIN_CP3 || (value >= SURR_LO && value <= SURR_HI))) begin
        bad = 1'b1;
      end else begin
        good     = 1'b1;
        good_cp  = value;
        good_len = size_r;
      end
    end else begin
      if (last) begin
        bad = 1'b1;
      end else begin
        partial_nxt = partial_r | {4'b0, b[5:0], 6'b0};
        pending_nxt = PEND_ONE;
      end
    end
    if (good || bad) begin
      pending_nxt = PEND_LEAD;
      partial_nxt = '0;
      size_nxt    = SEQ_LEN_NONE;
    end
    if (bad) begin
      discard_nxt = !last;
    end
  end

  assign res_vld          = step.vld && (good || bad);
  assign res.code_point   = good_cp;
  assign res.seq_length   = good_len;
  assign res.bad_sequence = bad;
  assign res.record_done  = last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= PEND_LEAD;
      partial_r <= '0;
      size_r    <= SEQ_LEN_NONE;
      discard_r <= 1'b0;
    end else if (step.fire) begin
      pending_r <= pending_nxt;
      partial_r <= partial_nxt;
      size_r    <= size_nxt;
      discard_r <= discard_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== design/u8d_out_stage.sv =====
// Result register: holds one decoded item until the receiver takes it.
`timescale 1ns / 1ps
`default_nettype none
module u8d_out_stage import u8d_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire u8d_step_t step,
  input  wire logic      res_vld,
  input  wire u8d_res_t  res,
  output logic           slot_free,
  output logic           out_valid,
  input  wire logic      out_ready,
  output u8d_res_t       out_item
);

  logic     out_vld_r, out_vld_nxt;
  u8d_res_t out_item_r;
  logic     load;

  assign slot_free = !out_vld_r || out_ready;
  assign load      = step.fire && res_vld;

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (out_vld_r && out_ready) begin
      out_vld_nxt = 1'b0;
    end
    if (load) begin
      out_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_item_r <= res;
    end
  end

  assign out_valid = out_vld_r;
  assign out_item  = out_item_r;

endmodule
`default_nettype wire

// ===== design/utf8_bmp_stream_decoder_top.sv =====
// Top level: UTF-8 decoder for the Basic Multilingual Plane, one byte per item.
//
// in_ch carries one raw byte and its last-byte flag per item. out_ch carries
// a code point, its sequence length (1..3, 0 on an error), an error flag and
// the record end flag. A lead or middle byte gives no result; the byte that
// completes a code point, or the first bad byte of a record, gives one result.
// After an error the rest of the record is swallowed without results.
// An accepted byte is held in the input register; when the result register
// can take an item, the byte is decoded and any result is loaded into it.
// Throughput: one byte per cycle while out_ch does not stall, set by the single
// decode step between the input register and the result register; the
// sequence state updates once per byte.
// Reset (rst_n low, synchronous) empties both registers and returns the
// decoder to expecting a lead byte outside any record error.
// When the receiver stalls, the result register holds its item, the input
// register holds the next byte, and in_ch.ready drops until the result is
// taken; no byte advances through the decoder while out_ch stalls, even one
// that gives no result.
`timescale 1ns / 1ps
`default_nettype none
module utf8_bmp_stream_decoder_top import u8d_pkg::*; (
  input wire logic   clk,
  input wire logic   rst_n,
  u8d_byte_if.sink   in_ch,
  u8d_cp_if.source   out_ch
);

  u8d_byte_t in_item;
  u8d_byte_t s1_item;
  u8d_step_t step;
  logic      slot_free;
  logic      res_vld;
  u8d_res_t  res;
  u8d_res_t  out_item;

  assign in_item.data_byte = in_ch.data_byte;
  assign in_item.last_byte = in_ch.last_byte;

  u8d_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_item   (in_item),
    .slot_free (slot_free),
    .step      (step),
    .s1_item   (s1_item)
  );

  u8d_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .s1_item (s1_item),
    .res_vld (res_vld),
    .res     (res)
  );

  u8d_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .res_vld   (res_vld),
    .res       (res),
    .slot_free (slot_free),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_item  (out_item)
  );

  assign out_ch.code_point   = out_item.code_point;
  assign out_ch.seq_length   = out_item.seq_length;
  assign out_ch.bad_sequence = out_item.bad_sequence;
  assign out_ch.record_done  = out_item.record_done;

endmodule
`default_nettype wire

// ===== design/u8d_checker.sv =====
// Checker: port-level properties of the decoder, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module u8d_checker import u8d_pkg::*; (
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             out_valid,
  input wire logic             out_ready,
  input wire logic [CP_W-1:0]  code_point,
  input wire logic [LEN_W-1:0] seq_length,
  input wire logic             bad_sequence
);

  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && bad_sequence |-> code_point == '0 && seq_length == SEQ_LEN_NONE)
    else $error("error item carries a code point or length");

  a_good_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !bad_sequence |-> seq_length != SEQ_LEN_NONE)
    else $error("decoded item without length");

  a_ascii_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !bad_sequence && seq_length == SEQ_LEN_1
      |-> code_point >= 16'h0020 && code_point <= 16'h007E)
    else $error("one-byte item outside printable range");

  a_three_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !bad_sequence && seq_length == SEQ_LEN_3
      |-> code_point >= MIN_CP3 && (code_point < SURR_LO || code_point > SURR_HI))
    else $error("three-byte item overlong or surrogate");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(code_point) && $stable(seq_length))
    else $error("stalled result item changed");

endmodule

bind utf8_bmp_stream_decoder_top u8d_checker u_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .code_point   (out_ch.code_point),
  .seq_length   (out_ch.seq_length),
  .bad_sequence (out_ch.bad_sequence)
);
`default_nettype wire
